### rtl/kvmt_pkg.sv
`default_nettype none

package kvmt_pkg;

  localparam int ENTRIES_DEF = 128;

  localparam int OPC_W = 2;
  localparam int KEY_W = 32;
  localparam int VAL_W = 32;
  localparam int CNT_W = 8;

  localparam int IN_BITS   = OPC_W + KEY_W + VAL_W;
  localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS   = 1 + VAL_W + 1 + CNT_W;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [OPC_W-1:0] OP_SET = 2'd0;
  localparam logic [OPC_W-1:0] OP_GET = 2'd1;
  localparam logic [OPC_W-1:0] OP_DEL = 2'd2;
  localparam logic [OPC_W-1:0] OP_NOP = 2'd3;

  // search token handed from cell to cell
  typedef struct packed {
    logic [OPC_W-1:0] opcode;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] write_value;
    logic             hit;
    logic [VAL_W-1:0] rdata;
    logic             free_found;
  } tok_t;

  // write-back command broadcast to every cell
  typedef struct packed {
    logic             upd;
    logic             ins;
    logic             del;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } wr_t;

endpackage

`default_nettype wire

### rtl/kvmt_cell.sv
`default_nettype none

module kvmt_cell (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          tok_in_vld,
  input  wire kvmt_pkg::tok_t tok_in,
  output logic               tok_out_vld,
  output kvmt_pkg::tok_t     tok_out,
  input  wire kvmt_pkg::wr_t wr
);

  logic [kvmt_pkg::KEY_W-1:0] key_r;
  logic [kvmt_pkg::VAL_W-1:0] value_r;
  logic                       valid_r;
  logic                       my_hit_r;
  logic                       my_free_r;
  logic                       tok_vld_r;
  kvmt_pkg::tok_t             tok_r;
  kvmt_pkg::tok_t             tok_nxt;
  logic                       match;

  assign match = valid_r && (key_r == tok_in.key);

  always_comb begin
    tok_nxt            = tok_in;
    tok_nxt.hit        = tok_in.hit | match;
    tok_nxt.rdata      = match ? value_r : tok_in.rdata;
    tok_nxt.free_found = tok_in.free_found | ~valid_r;
  end

  // token stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_vld_r <= 1'b0;
    end else begin
      tok_vld_r <= tok_in_vld;
    end
    tok_r <= tok_nxt;
  end

  // remember whether this cell is the match or the insertion target
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      my_hit_r  <= 1'b0;
      my_free_r <= 1'b0;
    end else if (tok_in_vld) begin
      my_hit_r  <= match;
      my_free_r <= ~valid_r & ~tok_in.free_found;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      if (wr.ins && my_free_r) begin
        valid_r <= 1'b1;
      end else if (wr.del && my_hit_r) begin
        valid_r <= 1'b0;
      end
    end
    if (wr.ins && my_free_r) begin
      key_r   <= wr.key;
      value_r <= wr.value;
    end else if (wr.upd && my_hit_r) begin
      value_r <= wr.value;
    end
  end

  assign tok_out_vld = tok_vld_r;
  assign tok_out     = tok_r;

endmodule

`default_nettype wire

### rtl/key_value_match_table.sv
`default_nettype none

// channel | dir | tdata fields, lowest bit first
// --------+-----+------------------------------------------------------------
// in_     | in  | opcode[1:0], key[33:2], write_value[65:34], zero pad to 72
// out_    | out | hit[0], read_value[32:1], table_full_drop[33],
//         |     | occupied[41:34], zero pad to 48
//
// the search token steps through the chain of ENTRIES cells one cell per cycle,
// waits in the hold register until the result register is free, then writes
// back and loads the result register. one item is in work at a time.
// reset clears all valid marks and the occupied count at once; keys and
// values are left as they are.
// a waiting result does not block the next item; only the write-back of that
// next item waits for out_tready.

module key_value_match_table #(
  parameter int ENTRIES = kvmt_pkg::ENTRIES_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // opcode, key, write_value
  input  wire logic [kvmt_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // hit, read_value, table_full_drop, occupied
  output logic [kvmt_pkg::OUT_DATA_W-1:0]      out_tdata
);

  localparam int OPC_LO = 0;
  localparam int KEY_LO = OPC_LO + kvmt_pkg::OPC_W;
  localparam int VAL_LO = KEY_LO + kvmt_pkg::KEY_W;

  // token chain: tok[i] feeds cell i, tok[ENTRIES] leaves the last cell
  logic           tok_vld [ENTRIES+1];
  kvmt_pkg::tok_t tok     [ENTRIES+1];
  kvmt_pkg::tok_t tok_head;
  kvmt_pkg::wr_t  wr;

  logic           busy_r;
  logic           done_vld_r;
  kvmt_pkg::tok_t done_r;
  logic [kvmt_pkg::CNT_W-1:0] count_r;
  logic [kvmt_pkg::CNT_W-1:0] count_nxt;
  logic                       out_tvalid_r;
  logic [kvmt_pkg::OUT_DATA_W-1:0] out_data_r;
  logic [kvmt_pkg::OUT_DATA_W-1:0] out_data_nxt;

  logic in_acc;
  logic finish;
  logic res_hit;
  logic res_drop;
  logic set_new;
  logic [kvmt_pkg::VAL_W-1:0] res_rdata;

  assign in_tready = ~busy_r;
  assign in_acc    = in_tvalid & in_tready;

  // fresh token from the accepted item
  always_comb begin
    tok_head.opcode         = in_tdata[OPC_LO +: kvmt_pkg::OPC_W];
    tok_head.key            = in_tdata[KEY_LO +: kvmt_pkg::KEY_W];
    tok_head.write_value    = in_tdata[VAL_LO +: kvmt_pkg::VAL_W];
    tok_head.hit            = 1'b0;
    tok_head.rdata          = '0;
    tok_head.free_found     = 1'b0;
  end

  assign tok_vld[0] = in_acc;
  assign tok[0]     = tok_head;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    kvmt_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .tok_in_vld  (tok_vld[i]),
      .tok_in      (tok[i]),
      .tok_out_vld (tok_vld[i+1]),
      .tok_out     (tok[i+1]),
      .wr          (wr)
    );
  end

  // finished search waits here until the result register is free
  assign finish = done_vld_r & (~out_tvalid_r | out_tready);

  // decision on the completed search
  always_comb begin
    res_hit   = (done_r.opcode != kvmt_pkg::OP_NOP) & done_r.hit;
    set_new   = (done_r.opcode == kvmt_pkg::OP_SET) & ~done_r.hit;
    res_drop  = set_new & ~done_r.free_found;
    res_rdata = (done_r.opcode == kvmt_pkg::OP_GET && done_r.hit) ? done_r.rdata : '0;

    wr.upd   = finish & (done_r.opcode == kvmt_pkg::OP_SET) & done_r.hit;
    wr.ins   = finish & set_new & done_r.free_found;
    wr.del   = finish & (done_r.opcode == kvmt_pkg::OP_DEL) & done_r.hit;
    wr.key   = done_r.key;
    wr.value = done_r.write_value;

    // occupied count wraps at 8 bits
    count_nxt = count_r;
    if (set_new && done_r.free_found) begin
      count_nxt = count_r + kvmt_pkg::CNT_W'(1);
    end else if (done_r.opcode == kvmt_pkg::OP_DEL && done_r.hit) begin
      count_nxt = count_r - kvmt_pkg::CNT_W'(1);
    end

    out_data_nxt = '0;
    out_data_nxt[kvmt_pkg::OUT_BITS-1:0] = {count_nxt, res_drop, res_rdata, res_hit};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b0;
      done_vld_r   <= 1'b0;
      count_r      <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        busy_r <= 1'b1;
      end else if (finish) begin
        busy_r <= 1'b0;
      end

      if (tok_vld[ENTRIES]) begin
        done_vld_r <= 1'b1;
      end else if (finish) begin
        done_vld_r <= 1'b0;
      end

      if (finish) begin
        count_r      <= count_nxt;
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end

    if (tok_vld[ENTRIES]) begin
      done_r <= tok[ENTRIES];
    end
    if (finish) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

### sim/key_value_match_table_tb.sv
`timescale 1ns / 1ps

module key_value_match_table_tb;

  localparam int ENTRIES   = kvmt_pkg::ENTRIES_DEF;
  localparam int KEY_POOL  = 200;
  localparam int N_RANDOM  = 1900;
  // slowest item: sender gap, search over every cell, write-back, receiver stall
  localparam longint CYCLE_LIMIT = longint'(N_RANDOM + 40) * (ENTRIES + 2 + 2 * 12 + 4) * 4;

  // one result item as it sits in out_tdata, lowest field at the bottom
  typedef struct packed {
    logic [kvmt_pkg::CNT_W-1:0] occupied;
    logic                       table_full_drop;
    logic [kvmt_pkg::VAL_W-1:0] read_value;
    logic                       hit;
  } kv_result_t;

  // shadow copy of the table plus the results it predicts, oldest first
  class kv_table_scoreboard;
    logic [kvmt_pkg::KEY_W-1:0] slot_key[ENTRIES];
    logic [kvmt_pkg::VAL_W-1:0] slot_val[ENTRIES];
    bit                         slot_valid[ENTRIES];
    logic [kvmt_pkg::CNT_W-1:0] occupied_count;
    kv_result_t                 pending_results[$];
    int                         error_count;

    function new();
      occupied_count = '0;
      error_count    = 0;
      foreach (slot_valid[i]) slot_valid[i] = 1'b0;
    endfunction

    // apply one accepted item to the shadow table and queue its result
    function void note_item(logic [kvmt_pkg::OPC_W-1:0] op, logic [kvmt_pkg::KEY_W-1:0] key,
                            logic [kvmt_pkg::VAL_W-1:0] wval);
      int match_idx;
      int free_idx;
      kv_result_t r;
      match_idx = -1;
      free_idx  = -1;
      for (int i = 0; i < ENTRIES; i++) begin
        if (slot_valid[i] && slot_key[i] == key && match_idx < 0) match_idx = i;
        if (!slot_valid[i] && free_idx < 0) free_idx = i;
      end
      r = '0;
      if (op != kvmt_pkg::OP_NOP && match_idx >= 0) r.hit = 1'b1;
      case (op)
        kvmt_pkg::OP_SET: begin
          if (match_idx >= 0) begin
            slot_val[match_idx] = wval;
          end else if (free_idx < 0) begin
            r.table_full_drop = 1'b1;
          end else begin
            slot_key[free_idx]   = key;
            slot_val[free_idx]   = wval;
            slot_valid[free_idx] = 1'b1;
            occupied_count       = occupied_count + 1'b1;
          end
        end
        kvmt_pkg::OP_GET: begin
          if (match_idx >= 0) r.read_value = slot_val[match_idx];
        end
        kvmt_pkg::OP_DEL: begin
          if (match_idx >= 0) begin
            slot_valid[match_idx] = 1'b0;
            occupied_count        = occupied_count - 1'b1;
          end
        end
        default: ;
      endcase
      r.occupied = occupied_count;
      pending_results.push_back(r);
    endfunction

    function void check_result(kv_result_t got);
      kv_result_t want;
      if (pending_results.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("unexpected result at %0t: %h", $realtime, got);
        return;
      end
      want = pending_results.pop_front();
      if (got.hit !== want.hit || got.read_value !== want.read_value ||
          got.table_full_drop !== want.table_full_drop ||
          got.occupied !== want.occupied) begin
        error_count++;
        if (error_count <= 10)
          $display("mismatch at %0t: hit %b/%b value %h/%h drop %b/%b occupied %0d/%0d",
                   $realtime, want.hit, got.hit, want.read_value, got.read_value,
                   want.table_full_drop, got.table_full_drop, want.occupied, got.occupied);
      end
    endfunction
  endclass

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [kvmt_pkg::IN_DATA_W-1:0]  in_tdata = '0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [kvmt_pkg::OUT_DATA_W-1:0] out_tdata;

  kv_table_scoreboard          sb;
  logic [kvmt_pkg::KEY_W-1:0]  key_pool[KEY_POOL];
  bit                          send_burst = 1'b0;
  bit                          recv_burst = 1'b0;
  longint                      cycle_count = 0;

  key_value_match_table #(.ENTRIES(ENTRIES)) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #5 clk = ~clk;

  // hard stop in case the block hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // present one item, keep tvalid up across back-to-back items
  task automatic drive_item(input logic [kvmt_pkg::OPC_W-1:0] op,
                            input logic [kvmt_pkg::KEY_W-1:0] key,
                            input logic [kvmt_pkg::VAL_W-1:0] wval);
    int gap;
    gap = send_burst ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(kvmt_pkg::IN_DATA_W - kvmt_pkg::IN_BITS){1'b0}}, wval, key, op};
    do @(posedge clk); while (!in_tready);
    sb.note_item(op, key, wval);
  endtask

  // hold off the sender until every outstanding result is back
  task automatic wait_all_results();
    in_tvalid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
  endtask

  // mostly keys from a small pool so sets, gets and deletes collide
  function automatic logic [kvmt_pkg::KEY_W-1:0] pick_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 2) return '0;
    if (r < 4) return '1;
    if (r < 15) return $urandom;
    return key_pool[$urandom_range(0, KEY_POOL - 1)];
  endfunction

  function automatic logic [kvmt_pkg::VAL_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom;
  endfunction

  // one stretch of random traffic with the given op mix in percent, rest no-ops
  task automatic run_phase(input int n_items, input int pct_set, input int pct_get,
                           input int pct_del);
    int r;
    logic [kvmt_pkg::OPC_W-1:0] op;
    for (int i = 0; i < n_items; i++) begin
      if (i % 50 == 0) send_burst = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < pct_set) op = kvmt_pkg::OP_SET;
      else if (r < pct_set + pct_get) op = kvmt_pkg::OP_GET;
      else if (r < pct_set + pct_get + pct_del) op = kvmt_pkg::OP_DEL;
      else op = kvmt_pkg::OP_NOP;
      drive_item(op, pick_key(), pick_value());
    end
    send_burst = 1'b0;
    wait_all_results();
  endtask

  initial begin
    sb = new();
    foreach (key_pool[i]) key_pool[i] = $urandom;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // result side: random stalls with occasional stretches of none
    fork
      begin : result_sink
        int stall;
        int n_results;
        n_results = 0;
        forever begin
          stall = recv_burst ? 0 : $urandom_range(0, 12);
          if (stall > 0) begin
            out_tready <= 1'b0;
            repeat (stall) @(posedge clk);
          end
          out_tready <= 1'b1;
          do @(posedge clk); while (!out_tvalid);
          sb.check_result(kv_result_t'(out_tdata[kvmt_pkg::OUT_BITS-1:0]));
          n_results++;
          if (n_results % 50 == 0) recv_burst = ($urandom_range(0, 3) == 0);
        end
      end
    join_none

    // directed: empty-table misses, extreme keys and values, update, delete, no-op
    drive_item(kvmt_pkg::OP_GET, 32'h0000_0000, 32'hFFFF_FFFF);
    drive_item(kvmt_pkg::OP_DEL, 32'h0000_0005, 32'h0000_0000);
    drive_item(kvmt_pkg::OP_NOP, 32'h0000_0000, 32'h0000_0000);
    drive_item(kvmt_pkg::OP_SET, 32'h0000_0000, 32'h0000_0000);
    drive_item(kvmt_pkg::OP_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    drive_item(kvmt_pkg::OP_GET, 32'h0000_0000, 32'h1234_5678);
    drive_item(kvmt_pkg::OP_GET, 32'hFFFF_FFFF, 32'h0000_0000);
    drive_item(kvmt_pkg::OP_SET, 32'h0000_0000, 32'h1234_5678);
    drive_item(kvmt_pkg::OP_GET, 32'h0000_0000, 32'h0000_0000);
    drive_item(kvmt_pkg::OP_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    drive_item(kvmt_pkg::OP_DEL, 32'h0000_0000, 32'h0000_0000);
    drive_item(kvmt_pkg::OP_GET, 32'h0000_0000, 32'h0000_0000);
    drive_item(kvmt_pkg::OP_DEL, 32'h0000_0000, 32'h0000_0000);
    // freed lowest slot gets reused
    drive_item(kvmt_pkg::OP_SET, 32'hA5A5_A5A5, 32'h5A5A_5A5A);
    drive_item(kvmt_pkg::OP_SET, 32'h5A5A_5A5A, 32'hA5A5_A5A5);
    drive_item(kvmt_pkg::OP_GET, 32'hA5A5_A5A5, 32'h0000_0000);
    drive_item(kvmt_pkg::OP_GET, 32'h5A5A_5A5A, 32'h0000_0000);
    drive_item(kvmt_pkg::OP_SET, 32'hFFFF_FFFF, 32'h0000_0000);
    drive_item(kvmt_pkg::OP_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    drive_item(kvmt_pkg::OP_DEL, 32'hFFFF_FFFF, 32'h0000_0000);
    drive_item(kvmt_pkg::OP_GET, 32'hFFFF_FFFF, 32'h0000_0000);
    wait_all_results();

    // set-heavy fill drives the table to full and into dropped sets
    run_phase(450, 75, 15, 5);
    // balanced churn around the full mark
    run_phase(650, 35, 35, 25);
    // delete-heavy drain down to an almost empty table
    run_phase(300, 15, 25, 55);
    run_phase(500, 30, 30, 30);

    // let any stray result show up before judging
    repeat (ENTRIES + 20) @(posedge clk);
    if (sb.error_count == 0 && sb.pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
